>>> rtl/bsp_pkg.sv
// Package for the buffered serial port: depths, codes, command type and back-end states.
package bsp_pkg;

    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 16;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int RX_CW    = $clog2(RX_DEPTH + 1);
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int TX_CW    = $clog2(TX_DEPTH + 1);

    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_POLL  = 2'd2;

    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_DATA  = 1'b1;

    localparam logic [7:0] EMPTY_BYTE = 8'hff;

    typedef enum logic [2:0] {
        CMD_COUNT,
        CMD_POP,
        CMD_WRITE,
        CMD_POLL,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic       rx_present;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RDWAIT,
        BK_OUT
    } t_bk_state;

endpackage

>>> rtl/buffered_serial_port_registers.sv
// Buffered serial port registers: receive and transmit byte FIFOs behind a bus.
// Commands pass through the command queue to the back end, which registers each result;
// a popped or polled byte reaches the result register from the registered RAM read.
// A poll drains bytes one by one (result register, then next RAM read); the back end ends
// each command before taking the next. A 2-entry command queue decouples input.
// Reset (synchronous, active low) empties both FIFOs and the command queue.
module buffered_serial_port_registers (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic       i_reg_select,
    input  logic [7:0] i_write_data,
    input  logic       i_rx_present,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic       o_read_empty_error,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_line_byte,
    output logic       o_tx_overflow,
    output logic       o_rx_overflow,
    output logic       o_last
);

    bsp_pkg::t_cmd front_cmd;
    bsp_pkg::t_cmd queue_cmd;
    logic          q_full, q_nonempty, q_pop;

    bsp_front u_front (
        .i_mode       (i_mode),
        .i_reg_select (i_reg_select),
        .i_write_data (i_write_data),
        .i_rx_present (i_rx_present),
        .i_rx_byte    (i_rx_byte),
        .o_cmd        (front_cmd)
    );

    assign o_ready = !q_full;

    bsp_cmd_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid && !q_full),
        .i_cmd      (front_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_cmd      (queue_cmd)
    );

    bsp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd_nonempty     (q_nonempty),
        .i_cmd              (queue_cmd),
        .o_cmd_pop          (q_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_read_data        (o_read_data),
        .o_read_empty_error (o_read_empty_error),
        .o_tx_valid         (o_tx_valid),
        .o_tx_line_byte     (o_tx_line_byte),
        .o_tx_overflow      (o_tx_overflow),
        .o_rx_overflow      (o_rx_overflow),
        .o_last             (o_last)
    );

endmodule

>>> rtl/bsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bsp_front.sv
// Front end: takes bus and line-poll transactions and turns them into commands.
module bsp_front (
    input  logic [1:0]      i_mode,
    input  logic            i_reg_select,
    input  logic [7:0]      i_write_data,
    input  logic            i_rx_present,
    input  logic [7:0]      i_rx_byte,
    output bsp_pkg::t_cmd   o_cmd
);

    always_comb begin
        o_cmd.data       = 8'h00;
        o_cmd.rx_present = 1'b0;
        unique case (i_mode)
            bsp_pkg::MODE_READ: begin
                o_cmd.kind = (i_reg_select == bsp_pkg::REG_COUNT) ?
                             bsp_pkg::CMD_COUNT : bsp_pkg::CMD_POP;
            end
            bsp_pkg::MODE_WRITE: begin
                o_cmd.kind = bsp_pkg::CMD_WRITE;
                o_cmd.data = i_write_data;
            end
            bsp_pkg::MODE_POLL: begin
                o_cmd.kind       = bsp_pkg::CMD_POLL;
                o_cmd.data       = i_rx_byte;
                o_cmd.rx_present = i_rx_present;
            end
            default: begin
                o_cmd.kind = bsp_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

>>> rtl/bsp_cmd_fifo.sv
// Short command queue between the front end and the back end.
module bsp_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsp_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output bsp_pkg::t_cmd   o_cmd
);

    bsp_pkg::t_cmd                 r_mem [bsp_pkg::CQ_DEPTH];
    logic [bsp_pkg::CQ_AW-1:0]     r_wptr, n_wptr;
    logic [bsp_pkg::CQ_AW-1:0]     r_rptr, n_rptr;
    logic [bsp_pkg::CQ_CW-1:0]     r_cnt,  n_cnt;

    function automatic logic [bsp_pkg::CQ_AW-1:0] ptr_inc(input logic [bsp_pkg::CQ_AW-1:0] p);
        ptr_inc = (p == bsp_pkg::CQ_AW'(bsp_pkg::CQ_DEPTH - 1)) ?
                  '0 : p + bsp_pkg::CQ_AW'(1);
    endfunction

    assign o_full     = (r_cnt == bsp_pkg::CQ_CW'(bsp_pkg::CQ_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_cmd      = r_mem[r_rptr];

    always_comb begin
        n_wptr = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr = i_pop  ? ptr_inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + bsp_pkg::CQ_CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - bsp_pkg::CQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/bsp_back.sv
// Back end: owns both byte FIFOs, executes commands and holds the result register.
module bsp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_nonempty,
    input  bsp_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_read_data,
    output logic            o_read_empty_error,
    output logic            o_tx_valid,
    output logic [7:0]      o_tx_line_byte,
    output logic            o_tx_overflow,
    output logic            o_rx_overflow,
    output logic            o_last
);

    localparam int RXS = bsp_pkg::RX_CW + 1;
    localparam int TXS = bsp_pkg::TX_CW + 1;

    bsp_pkg::t_bk_state           r_state, n_state;
    logic [bsp_pkg::RX_AW-1:0]    r_rx_head, n_rx_head;
    logic [bsp_pkg::RX_CW-1:0]    r_rx_count, n_rx_count;
    logic [bsp_pkg::TX_AW-1:0]    r_tx_head, n_tx_head;
    logic [bsp_pkg::TX_CW-1:0]    r_tx_count, n_tx_count;

    // result register and drain bookkeeping (no reset needed)
    logic       r_src_tx, n_src_tx;
    logic       r_rxo_pend, n_rxo_pend;
    logic [7:0] r_read_data, n_read_data;
    logic       r_err, n_err;
    logic       r_txv, n_txv;
    logic [7:0] r_txb, n_txb;
    logic       r_txo, n_txo;
    logic       r_rxo, n_rxo;
    logic       r_last, n_last;

    logic                      rx_we, tx_we;
    logic [bsp_pkg::RX_AW-1:0] rx_waddr;
    logic [bsp_pkg::TX_AW-1:0] tx_waddr;
    logic [7:0]                rx_rdata, tx_rdata;
    logic [RXS-1:0]            rx_sum;
    logic [TXS-1:0]            tx_sum;
    logic                      rx_full, tx_full, rx_empty, tx_empty;
    logic                      take;

    bsp_ram #(.WIDTH(8), .DEPTH(bsp_pkg::RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (i_cmd.data),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    bsp_ram #(.WIDTH(8), .DEPTH(bsp_pkg::TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_cmd.data),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

    assign rx_full  = (r_rx_count == bsp_pkg::RX_CW'(bsp_pkg::RX_DEPTH));
    assign tx_full  = (r_tx_count == bsp_pkg::TX_CW'(bsp_pkg::TX_DEPTH));
    assign rx_empty = (r_rx_count == '0);
    assign tx_empty = (r_tx_count == '0);
    assign take     = (r_state == bsp_pkg::BK_IDLE) && i_cmd_nonempty;

    // tail = (head + count) mod depth; the sum stays below twice the depth
    always_comb begin
        rx_sum = RXS'(r_rx_head) + RXS'(r_rx_count);
        if (rx_sum >= RXS'(bsp_pkg::RX_DEPTH)) begin
            rx_sum = rx_sum - RXS'(bsp_pkg::RX_DEPTH);
        end
        rx_waddr = rx_sum[bsp_pkg::RX_AW-1:0];
        tx_sum = TXS'(r_tx_head) + TXS'(r_tx_count);
        if (tx_sum >= TXS'(bsp_pkg::TX_DEPTH)) begin
            tx_sum = tx_sum - TXS'(bsp_pkg::TX_DEPTH);
        end
        tx_waddr = tx_sum[bsp_pkg::TX_AW-1:0];
    end

    function automatic logic [bsp_pkg::RX_AW-1:0] rx_inc(input logic [bsp_pkg::RX_AW-1:0] p);
        rx_inc = (p == bsp_pkg::RX_AW'(bsp_pkg::RX_DEPTH - 1)) ?
                 '0 : p + bsp_pkg::RX_AW'(1);
    endfunction

    function automatic logic [bsp_pkg::TX_AW-1:0] tx_inc(input logic [bsp_pkg::TX_AW-1:0] p);
        tx_inc = (p == bsp_pkg::TX_AW'(bsp_pkg::TX_DEPTH - 1)) ?
                 '0 : p + bsp_pkg::TX_AW'(1);
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsp_pkg::BK_IDLE: begin
                if (take) begin
                    if ((i_cmd.kind == bsp_pkg::CMD_POP && !rx_empty) ||
                        (i_cmd.kind == bsp_pkg::CMD_POLL && !tx_empty)) begin
                        n_state = bsp_pkg::BK_RDWAIT;
                    end else begin
                        n_state = bsp_pkg::BK_OUT;
                    end
                end
            end
            bsp_pkg::BK_RDWAIT: begin
                n_state = bsp_pkg::BK_OUT;
            end
            bsp_pkg::BK_OUT: begin
                if (i_ready) begin
                    n_state = r_last ? bsp_pkg::BK_IDLE : bsp_pkg::BK_RDWAIT;
                end
            end
            default: begin
                n_state = bsp_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath and FIFO control
    always_comb begin
        n_rx_head   = r_rx_head;
        n_rx_count  = r_rx_count;
        n_tx_head   = r_tx_head;
        n_tx_count  = r_tx_count;
        n_src_tx    = r_src_tx;
        n_rxo_pend  = r_rxo_pend;
        n_read_data = r_read_data;
        n_err       = r_err;
        n_txv       = r_txv;
        n_txb       = r_txb;
        n_txo       = r_txo;
        n_rxo       = r_rxo;
        n_last      = r_last;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        o_cmd_pop   = take;

        unique case (r_state)
            bsp_pkg::BK_IDLE: begin
                if (take) begin
                    n_read_data = 8'h00;
                    n_err       = 1'b0;
                    n_txv       = 1'b0;
                    n_txb       = 8'h00;
                    n_txo       = 1'b0;
                    n_rxo       = 1'b0;
                    n_last      = 1'b1;
                    unique case (i_cmd.kind)
                        bsp_pkg::CMD_COUNT: begin
                            n_read_data = 8'(r_rx_count);
                        end
                        bsp_pkg::CMD_POP: begin
                            if (rx_empty) begin
                                n_read_data = bsp_pkg::EMPTY_BYTE;
                                n_err       = 1'b1;
                            end else begin
                                n_src_tx   = 1'b0;
                                n_rx_head  = rx_inc(r_rx_head);
                                n_rx_count = r_rx_count - bsp_pkg::RX_CW'(1);
                            end
                        end
                        bsp_pkg::CMD_WRITE: begin
                            if (tx_full) begin
                                n_txo = 1'b1;
                            end else begin
                                tx_we      = 1'b1;
                                n_tx_count = r_tx_count + bsp_pkg::TX_CW'(1);
                            end
                        end
                        bsp_pkg::CMD_POLL: begin
                            if (i_cmd.rx_present && !rx_full) begin
                                rx_we      = 1'b1;
                                n_rx_count = r_rx_count + bsp_pkg::RX_CW'(1);
                            end
                            n_rxo      = i_cmd.rx_present && rx_full;
                            n_rxo_pend = i_cmd.rx_present && rx_full;
                            if (!tx_empty) begin
                                n_src_tx   = 1'b1;
                                n_tx_head  = tx_inc(r_tx_head);
                                n_tx_count = r_tx_count - bsp_pkg::TX_CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bsp_pkg::BK_RDWAIT: begin
                // RAM data for the head read issued last cycle is now valid
                if (r_src_tx) begin
                    n_read_data = 8'h00;
                    n_err       = 1'b0;
                    n_txv       = 1'b1;
                    n_txb       = tx_rdata;
                    n_txo       = 1'b0;
                    n_rxo       = r_rxo_pend;
                    n_last      = tx_empty;
                    n_rxo_pend  = 1'b0;
                end else begin
                    n_read_data = rx_rdata;
                    n_last      = 1'b1;
                end
            end
            bsp_pkg::BK_OUT: begin
                if (i_ready && !r_last) begin
                    n_tx_head  = tx_inc(r_tx_head);
                    n_tx_count = r_tx_count - bsp_pkg::TX_CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bsp_pkg::BK_IDLE;
            r_rx_head  <= '0;
            r_rx_count <= '0;
            r_tx_head  <= '0;
            r_tx_count <= '0;
        end else begin
            r_state    <= n_state;
            r_rx_head  <= n_rx_head;
            r_rx_count <= n_rx_count;
            r_tx_head  <= n_tx_head;
            r_tx_count <= n_tx_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src_tx    <= n_src_tx;
        r_rxo_pend  <= n_rxo_pend;
        r_read_data <= n_read_data;
        r_err       <= n_err;
        r_txv       <= n_txv;
        r_txb       <= n_txb;
        r_txo       <= n_txo;
        r_rxo       <= n_rxo;
        r_last      <= n_last;
    end

    assign o_valid            = (r_state == bsp_pkg::BK_OUT);
    assign o_read_data        = r_read_data;
    assign o_read_empty_error = r_err;
    assign o_tx_valid         = r_txv;
    assign o_tx_line_byte     = r_txb;
    assign o_tx_overflow      = r_txo;
    assign o_rx_overflow      = r_rxo;
    assign o_last             = r_last;

endmodule

>>> rtl/bsp_checker.sv
// Port-level checker for the buffered serial port, bound to the top level.
module bsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data,
    input logic       o_read_empty_error,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_line_byte,
    input logic       o_tx_overflow,
    input logic       o_rx_overflow,
    input logic       o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data) && $stable(o_tx_line_byte)
            && $stable(o_last) && $stable(o_tx_valid))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_read_empty_error |-> o_read_data == 8'hff && o_last && !o_tx_valid)
        else $error("empty read error with bad result fields");

    a_not_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_tx_valid)
        else $error("non-final result outside a transmit drain");

    a_txovf_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tx_overflow |-> o_last && !o_tx_valid && !o_rx_overflow)
        else $error("transmit overflow on a drain result");

endmodule

bind buffered_serial_port_registers bsp_checker u_bsp_checker (.*);

>>> test/buffered_serial_port_registers_tb.sv
// Self-checking testbench for the buffered serial port registers: mixed bus and poll traffic.
module buffered_serial_port_registers_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int LONG_HOLD = 90;
    localparam int ITEM_TARGET = 300;
    localparam int CALM_AFTER = 255;

    typedef struct packed {
        logic [7:0] read_data;
        logic       empty_err;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_ovf;
        logic       rx_ovf;
        logic       last;
    } t_port_result;

    // Tracks both FIFOs and holds the results the port still owes.
    class port_tracker;
        logic [7:0]   rx_mem[bsp_pkg::RX_DEPTH];
        logic [7:0]   tx_mem[bsp_pkg::TX_DEPTH];
        int           rx_rd, rx_cnt, tx_rd, tx_cnt;
        t_port_result awaited_results[$];
        int           n_errors, n_checked;
        int           n_mode[4];
        int           n_tx_drop, n_rx_drop, n_empty_pop, longest_drain;

        function new();
            rx_rd = 0;
            rx_cnt = 0;
            tx_rd = 0;
            tx_cnt = 0;
            n_errors = 0;
            n_checked = 0;
            n_mode = '{0, 0, 0, 0};
            n_tx_drop = 0;
            n_rx_drop = 0;
            n_empty_pop = 0;
            longest_drain = 0;
        endfunction

        function void note_transaction(logic [1:0] m, logic sel, logic [7:0] wd,
                                       logic rxp, logic [7:0] rxb);
            t_port_result r;
            logic         rx_drop;
            int           drained;
            r = '0;
            rx_drop = 1'b0;
            drained = 0;
            n_mode[m]++;
            case (m)
                bsp_pkg::MODE_READ: begin
                    if (sel == bsp_pkg::REG_COUNT) begin
                        r.read_data = rx_cnt[7:0];
                    end else if (rx_cnt > 0) begin
                        r.read_data = rx_mem[rx_rd];
                        rx_rd = (rx_rd + 1) % bsp_pkg::RX_DEPTH;
                        rx_cnt--;
                    end else begin
                        r.read_data = bsp_pkg::EMPTY_BYTE;
                        r.empty_err = 1'b1;
                        n_empty_pop++;
                    end
                    r.last = 1'b1;
                    awaited_results.push_back(r);
                end
                bsp_pkg::MODE_WRITE: begin
                    if (tx_cnt < bsp_pkg::TX_DEPTH) begin
                        tx_mem[(tx_rd + tx_cnt) % bsp_pkg::TX_DEPTH] = wd;
                        tx_cnt++;
                    end else begin
                        r.tx_ovf = 1'b1;
                        n_tx_drop++;
                    end
                    r.last = 1'b1;
                    awaited_results.push_back(r);
                end
                bsp_pkg::MODE_POLL: begin
                    if (rxp) begin
                        if (rx_cnt < bsp_pkg::RX_DEPTH) begin
                            rx_mem[(rx_rd + rx_cnt) % bsp_pkg::RX_DEPTH] = rxb;
                            rx_cnt++;
                        end else begin
                            rx_drop = 1'b1;
                            n_rx_drop++;
                        end
                    end
                    if (tx_cnt == 0) begin
                        r.rx_ovf = rx_drop;
                        r.last = 1'b1;
                        awaited_results.push_back(r);
                    end
                    // drain everything, oldest first; the rx drop flag rides on the first byte
                    while (tx_cnt > 0) begin
                        r = '0;
                        r.tx_valid = 1'b1;
                        r.tx_byte = tx_mem[tx_rd];
                        r.rx_ovf = (drained == 0) ? rx_drop : 1'b0;
                        r.last = (tx_cnt == 1);
                        awaited_results.push_back(r);
                        tx_rd = (tx_rd + 1) % bsp_pkg::TX_DEPTH;
                        tx_cnt--;
                        drained++;
                    end
                    if (drained > longest_drain) longest_drain = drained;
                end
                default: begin
                    r.last = 1'b1;
                    awaited_results.push_back(r);
                end
            endcase
        endfunction

        function void cmp_field(string field, logic [7:0] e, logic [7:0] a);
            if (a !== e) begin
                n_errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
            end
        endfunction

        function void check_result(t_port_result act);
            t_port_result exp;
            n_checked++;
            if (awaited_results.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected result, expected none, actual %p", $time, act);
                return;
            end
            exp = awaited_results.pop_front();
            cmp_field("read_data", exp.read_data, act.read_data);
            cmp_field("read_empty_error", 8'(exp.empty_err), 8'(act.empty_err));
            cmp_field("tx_valid", 8'(exp.tx_valid), 8'(act.tx_valid));
            cmp_field("tx_line_byte", exp.tx_byte, act.tx_byte);
            cmp_field("tx_overflow", 8'(exp.tx_ovf), 8'(act.tx_ovf));
            cmp_field("rx_overflow", 8'(exp.rx_ovf), 8'(act.rx_ovf));
            cmp_field("last", 8'(exp.last), 8'(act.last));
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_mode;
    logic       i_reg_select;
    logic [7:0] i_write_data;
    logic       i_rx_present;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_read_data;
    logic       o_read_empty_error;
    logic       o_tx_valid;
    logic [7:0] o_tx_line_byte;
    logic       o_tx_overflow;
    logic       o_rx_overflow;
    logic       o_last;

    port_tracker tracker = new();
    bit          calm = 1'b0;
    int          n_sent = 0;

    buffered_serial_port_registers uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_reg_select       (i_reg_select),
        .i_write_data       (i_write_data),
        .i_rx_present       (i_rx_present),
        .i_rx_byte          (i_rx_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_read_data        (o_read_data),
        .o_read_empty_error (o_read_empty_error),
        .o_tx_valid         (o_tx_valid),
        .o_tx_line_byte     (o_tx_line_byte),
        .o_tx_overflow      (o_tx_overflow),
        .o_rx_overflow      (o_rx_overflow),
        .o_last             (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic rnd1();
        return 1'($urandom);
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // One input transaction; valid stays high into the next call unless a gap is taken.
    task automatic send_item(input logic [1:0] m, input logic sel, input logic [7:0] wd,
                             input logic rxp, input logic [7:0] rxb);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= m;
        i_reg_select <= sel;
        i_write_data <= wd;
        i_rx_present <= rxp;
        i_rx_byte    <= rxb;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_transaction(m, sel, wd, rxp, rxb);
        n_sent++;
    endtask

    // Result side: random stall bursts plus one long hold-off to back the port up.
    initial begin
        int  hold_left;
        bit  long_hold_done;
        hold_left = 0;
        long_hold_done = 1'b0;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                tracker.check_result({o_read_data, o_read_empty_error, o_tx_valid,
                                      o_tx_line_byte, o_tx_overflow, o_rx_overflow, o_last});
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= (hold_left == 0);
            end else if (!long_hold_done && tracker.n_checked >= 40) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 7);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int seg, n, k;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_mode       <= bsp_pkg::MODE_READ;
        i_reg_select <= bsp_pkg::REG_COUNT;
        i_write_data <= 8'h00;
        i_rx_present <= 1'b0;
        i_rx_byte    <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty reads, ignored rx byte, extreme bytes, drains, unused mode
        send_item(bsp_pkg::MODE_READ,  bsp_pkg::REG_COUNT, 8'h00, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_READ,  bsp_pkg::REG_DATA,  8'h00, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_POLL,  bsp_pkg::REG_COUNT, 8'h00, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_POLL,  bsp_pkg::REG_DATA,  8'hff, 1'b0, 8'hff);
        send_item(bsp_pkg::MODE_POLL,  bsp_pkg::REG_COUNT, 8'h00, 1'b1, 8'h00);
        send_item(bsp_pkg::MODE_POLL,  bsp_pkg::REG_COUNT, 8'h00, 1'b1, 8'hff);
        send_item(bsp_pkg::MODE_READ,  bsp_pkg::REG_COUNT, 8'hff, 1'b1, 8'hff);
        send_item(bsp_pkg::MODE_WRITE, bsp_pkg::REG_COUNT, 8'h00, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_WRITE, bsp_pkg::REG_COUNT, 8'hff, 1'b1, 8'hff);
        send_item(bsp_pkg::MODE_WRITE, bsp_pkg::REG_DATA,  8'h5a, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_POLL,  bsp_pkg::REG_DATA,  8'hff, 1'b1, 8'ha5);
        send_item(bsp_pkg::MODE_READ,  bsp_pkg::REG_DATA,  8'h00, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_READ,  bsp_pkg::REG_DATA,  8'h00, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_READ,  bsp_pkg::REG_COUNT, 8'h00, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_READ,  bsp_pkg::REG_DATA,  8'h00, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_READ,  bsp_pkg::REG_DATA,  8'h00, 1'b0, 8'h00);
        send_item(MODE_UNUSED,         bsp_pkg::REG_DATA,  8'hff, 1'b1, 8'hff);
        send_item(MODE_UNUSED,         bsp_pkg::REG_COUNT, 8'h00, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_WRITE, bsp_pkg::REG_COUNT, 8'h81, 1'b0, 8'h00);
        send_item(bsp_pkg::MODE_POLL,  bsp_pkg::REG_COUNT, 8'h00, 1'b0, 8'h00);

        while (n_sent < ITEM_TARGET) begin
            if (n_sent >= CALM_AFTER) calm = 1'b1;
            seg = $urandom_range(0, 11);
            n = $urandom_range(1, 8);
            case (seg)
                0, 1, 2: begin
                    for (k = 0; k < n; k++)
                        send_item(bsp_pkg::MODE_WRITE, rnd1(), rnd8(), rnd1(), rnd8());
                end
                3, 4: begin
                    for (k = 0; k < n; k++)
                        send_item(bsp_pkg::MODE_POLL, rnd1(), rnd8(),
                                  $urandom_range(0, 7) != 0, rnd8());
                end
                5, 6: begin
                    for (k = 0; k < n; k++)
                        send_item(bsp_pkg::MODE_READ, $urandom_range(0, 3) != 0, rnd8(),
                                  rnd1(), rnd8());
                end
                7: begin
                    // fill transmit up to or past its depth, then one poll drains it in a single long burst
                    for (k = 0; k < bsp_pkg::TX_DEPTH + $urandom_range(0, 3); k++)
                        send_item(bsp_pkg::MODE_WRITE, rnd1(), rnd8(), rnd1(), rnd8());
                    send_item(bsp_pkg::MODE_POLL, rnd1(), rnd8(), rnd1(), rnd8());
                end
                8: begin
                    for (k = 0; k < bsp_pkg::RX_DEPTH + $urandom_range(0, 3); k++)
                        send_item(bsp_pkg::MODE_POLL, rnd1(), rnd8(), 1'b1, rnd8());
                    for (k = 0; k <= bsp_pkg::RX_DEPTH; k++)
                        send_item(bsp_pkg::MODE_READ, bsp_pkg::REG_DATA, rnd8(), rnd1(),
                                  rnd8());
                end
                default: begin
                    send_item(2'($urandom_range(0, 3)), rnd1(), rnd8(), rnd1(), rnd8());
                end
            endcase
        end
        i_valid <= 1'b0;

        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d transactions (read %0d, write %0d, poll %0d, unused %0d),",
                 n_sent, tracker.n_mode[0], tracker.n_mode[1], tracker.n_mode[2],
                 tracker.n_mode[3]);
        $display("%0d results checked; transmit drops %0d, receive drops %0d, %s",
                 tracker.n_checked, tracker.n_tx_drop, tracker.n_rx_drop,
                 $sformatf("empty pops %0d, longest drain %0d bytes.",
                           tracker.n_empty_pop, tracker.longest_drain));
        if (tracker.n_errors == 0)
            $display("buffered_serial_port_registers_tb OK");
        else
            $display("buffered_serial_port_registers_tb NOT OK");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Timeout with %0d results still outstanding.", tracker.awaited_results.size());
        $display("buffered_serial_port_registers_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
rtl/bsp_pkg.sv
rtl/bsp_ram.sv
rtl/bsp_front.sv
rtl/bsp_cmd_fifo.sv
rtl/bsp_back.sv
rtl/buffered_serial_port_registers.sv
rtl/bsp_checker.sv
test/buffered_serial_port_registers_tb.sv
